/* hdl/periodic_and_daily_event_scheduler_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the periodic and daily event scheduler
// Clocked property checks; empty when building for synthesis.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_AND_DAILY_EVENT_SCHEDULER_DEFINES_SVH
`define PERIODIC_AND_DAILY_EVENT_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// check a property with reset masking
`define PDES_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("pdes assertion failed");
// check a property at every edge, reset included
`define PDES_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pdes assertion failed");
`else
`define PDES_ASSERT(lbl, clk, rst_n, prop)
`define PDES_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hdl/pdes_pkg.sv */
// ---------------------------------------------------------------------------
// pdes_pkg
// Widths, time constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package pdes_pkg;

    localparam int NOW_W  = 48;
    localparam int NCT_W  = 49;
    localparam int IV_W   = 42;
    localparam int HOUR_W = 27;
    localparam int RH_W   = 22;
    localparam int DAY_W  = 22;
    localparam int LFD_W  = 23;
    localparam int HOD_W  = 5;
    localparam int NEXT_W = 28;
    localparam int SECS_W = 18;
    localparam int DIVD_W = 49;
    localparam int DIVS_W = 42;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;
    localparam int HREM_W = 17;
    localparam int X3_W   = 26;

    localparam logic [IV_W-1:0] MS_SEC    = 42'd1000;
    localparam logic [IV_W-1:0] MS_HOUR   = 42'd3600000;
    localparam logic [IV_W-1:0] HOURS_DAY = 42'd24;

    // hour split: now >> 7 divided by 28125 (3600000 >> 7), estimated from
    // the top 32 bits with floor(2^41 / 28125), then fixed up by at most two
    localparam logic [HOUR_W-1:0] HOUR_RECIP  = 27'd78187493;
    localparam logic [HREM_W-1:0] HOUR_ODD    = 17'd28125;
    localparam logic [HREM_W-1:0] HOUR_ODD_X2 = 17'd56250;

    // exact divide by 3 for values below 2^25
    localparam logic [23:0] DIV3_RECIP = 24'd11184811;
    localparam int          DIV3_SH    = 25;

    // exact divide by 125 for values below 2^26
    localparam logic [26:0] SEC_RECIP = 27'd68719477;
    localparam int          SEC_SH    = 33;

    localparam logic [CIDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HOUR     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CAP      = 2'd2;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic load_in;
        logic hr_mul;
        logic hr_rem;
        logic save_hour;
        logic day_mul;
        logic save_day;
        logic tick_eval;
        logic div_start;
        logic save_cap;
        logic calc_day;
        logic calc_next;
        logic sec_add;
        logic save_secs;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic is_query;
        logic cap_hit;
    } t_stat;

endpackage

/* hdl/pdes_div.sv */
// ---------------------------------------------------------------------------
// pdes_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pdes_div
    import pdes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quot;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [DIVS_W:0]   w_sh;
    logic [DIVS_W:0]   w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_quot[DIVD_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = !w_diff[DIVS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quot <= {r_quot[DIVD_W-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[DIVS_W-1:0] : w_sh[DIVS_W-1:0];
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hdl/pdes_dp.sv */
// ---------------------------------------------------------------------------
// pdes_dp
// Datapath: settings, schedule state, divider and result word.
// ---------------------------------------------------------------------------
module pdes_dp
    import pdes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_func,
    input  logic [NOW_W-1:0]  i_now_ms,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_capture_due,
    output logic              o_daily_due,
    output logic [SECS_W-1:0] o_sleep_seconds
);

    localparam int Y_W  = NOW_W - 7;
    localparam int QP_W = 32 + HOUR_W;
    localparam int DP_W = 48;
    localparam int SP_W = X3_W + 27;

    logic [CFG_W-1:0]  r_cfg_iv;
    logic [HOD_W-1:0]  r_cfg_hour;
    logic [CFG_W-1:0]  r_cfg_cap;
    logic [IV_W-1:0]   r_iv;
    logic [IV_W-1:0]   r_lim;
    logic              r_func;
    logic [NOW_W-1:0]  r_now;
    logic [NCT_W-1:0]  r_nct;
    logic [LFD_W-1:0]  r_lfd;
    logic              r_lfv;
    logic [HOUR_W-1:0] r_qe;
    logic [HREM_W-1:0] r_hr;
    logic [HOUR_W-1:0] r_h;
    logic [RH_W-1:0]   r_rh;
    logic [DAY_W-1:0]  r_day;
    logic [HOD_W-1:0]  r_hod;
    logic              r_cap;
    logic              r_dly;
    logic [NEXT_W-1:0] r_uday;
    logic [NEXT_W-1:0] r_next;
    logic [X3_W-1:0]   r_x3;
    logic [SECS_W-1:0] r_secs;

    logic [DIVD_W-1:0]        w_dvd;
    logic [DIVS_W-1:0]        w_dvs;
    logic                     w_done;
    logic [DIVS_W-1:0]        w_rem;
    logic [QP_W-1:0]          w_qprod;
    logic [Y_W-1:0]           w_qmul;
    logic [Y_W-1:0]           w_hdiff;
    logic                     w_h1;
    logic                     w_h2;
    logic [HOUR_W-1:0]        w_hq_fix;
    logic [HREM_W-1:0]        w_hr_fix;
    logic [DP_W-1:0]          w_dprod;
    logic [NEXT_W:0]          w_rnd;
    logic [SP_W-1:0]          w_sprod;
    logic [SP_W-SEC_SH-1:0]   w_sq;
    logic                     w_cap_hit;
    logic                     w_fired;
    logic                     w_ahead;
    logic [NOW_W-1:0]         w_base;
    logic [5:0]               w_k;
    logic [NEXT_W-1:0]        w_kms;
    logic [NCT_W-1:0]         w_ucap;
    logic [NEXT_W-1:0]        w_min;

    assign w_cap_hit = (r_nct == '0) || ({1'b0, r_now} >= r_nct);
    assign w_fired   = r_lfv && (r_lfd == {1'b0, r_day});
    assign w_ahead   = (r_cfg_hour > r_hod) && !w_fired;
    assign w_base    = (r_nct == '0) ? r_now : r_nct[NOW_W-1:0];
    assign w_k       = ({1'b0, r_cfg_hour} - {1'b0, r_hod}) + (w_ahead ? 6'd0 : 6'd24);
    assign w_kms     = NEXT_W'(w_k) * NEXT_W'(MS_HOUR);
    assign w_ucap    = ({1'b0, r_now} < r_nct) ? (r_nct - {1'b0, r_now}) : NCT_W'(r_iv);
    assign w_min     = (w_ucap < NCT_W'(r_uday)) ? w_ucap[NEXT_W-1:0] : r_uday;

    // hour of time: estimate, remainder against the estimate, fix up
    assign w_qprod  = QP_W'(r_now[NOW_W-1:16]) * QP_W'(HOUR_RECIP);
    assign w_qmul   = Y_W'(r_qe) * Y_W'(HOUR_ODD);
    assign w_hdiff  = r_now[NOW_W-1:7] - w_qmul;
    assign w_h2     = (r_hr >= HOUR_ODD_X2);
    assign w_h1     = (r_hr >= HOUR_ODD);
    assign w_hq_fix = r_qe + (w_h2 ? HOUR_W'(2) : (w_h1 ? HOUR_W'(1) : '0));
    assign w_hr_fix = w_h2 ? (r_hr - HOUR_ODD_X2) : (w_h1 ? (r_hr - HOUR_ODD) : r_hr);

    // day from hours: (h >> 3) / 3
    assign w_dprod  = DP_W'(r_h[HOUR_W-1:3]) * DP_W'(DIV3_RECIP);

    // rounded-up seconds: ((next + 999) >> 3) / 125
    assign w_rnd    = {1'b0, r_next} + (NEXT_W+1)'(MS_SEC - 1'b1);
    assign w_sprod  = SP_W'(r_x3) * SP_W'(SEC_RECIP);
    assign w_sq     = w_sprod[SP_W-1:SEC_SH];

    // divider serves only the capture catch-up remainder
    assign w_dvd = {1'b0, r_now - w_base};
    assign w_dvs = r_iv;

    pdes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_iv   <= '0;
            r_cfg_hour <= '0;
            r_cfg_cap  <= '0;
            r_nct      <= '0;
            r_lfv      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_INTERVAL: r_cfg_iv   <= i_cfg_data;
                    CFG_HOUR:     r_cfg_hour <= i_cfg_data[HOD_W-1:0];
                    CFG_CAP:      r_cfg_cap  <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_cmd.tick_eval && (r_hod == r_cfg_hour) && !w_fired) begin
                r_lfd <= {1'b0, r_day};
                r_lfv <= 1'b1;
            end
            if (i_cmd.save_cap) begin
                r_nct <= {1'b0, r_now} - NCT_W'(w_rem) + NCT_W'(r_iv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_iv  <= (r_cfg_iv == '0) ? MS_HOUR : IV_W'(r_cfg_iv) * MS_SEC;
        r_lim <= IV_W'(r_cfg_cap) * MS_SEC;
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_now  <= i_now_ms;
        end
        if (i_cmd.hr_mul) begin
            r_qe <= w_qprod[QP_W-1:32];
        end
        if (i_cmd.hr_rem) begin
            r_hr <= w_hdiff[HREM_W-1:0];
        end
        if (i_cmd.save_hour) begin
            r_h  <= w_hq_fix;
            r_rh <= {w_hr_fix[14:0], r_now[6:0]};
        end
        if (i_cmd.day_mul) begin
            r_day <= w_dprod[DIV3_SH +: DAY_W];
        end
        if (i_cmd.save_day) begin
            r_hod <= HOD_W'(r_h - HOUR_W'(r_day) * HOUR_W'(HOURS_DAY));
        end
        if (i_cmd.tick_eval) begin
            r_cap <= w_cap_hit;
            r_dly <= (r_hod == r_cfg_hour) && !w_fired;
        end
        if (i_cmd.calc_day) begin
            r_uday <= w_kms - NEXT_W'(r_rh);
        end
        if (i_cmd.calc_next) begin
            r_next <= ((r_lim != '0) && (r_lim < IV_W'(w_min))) ? r_lim[NEXT_W-1:0] : w_min;
        end
        if (i_cmd.sec_add) begin
            r_x3 <= w_rnd[NEXT_W:3];
        end
        if (i_cmd.save_secs) begin
            r_secs <= (w_sq == '0) ? SECS_W'(1) : w_sq[SECS_W-1:0];
        end
        if (i_cmd.out_load) begin
            o_capture_due   <= (r_func == FUNC_TICK) && r_cap;
            o_daily_due     <= (r_func == FUNC_TICK) && r_dly;
            o_sleep_seconds <= (r_func == FUNC_QUERY) ? r_secs : '0;
        end
    end

    assign o_stat.div_done = w_done;
    assign o_stat.is_query = (r_func == FUNC_QUERY);
    assign o_stat.cap_hit  = w_cap_hit;

endmodule

/* hdl/pdes_ctrl.sv */
// ---------------------------------------------------------------------------
// pdes_ctrl
// Sequencer: steps one word through the datapath passes and hands off.
// ---------------------------------------------------------------------------
`include "periodic_and_daily_event_scheduler_defines.svh"
module pdes_ctrl
    import pdes_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_HOUR,
        S_HOUR_FIX,
        S_HOUR_ADJ,
        S_DAY,
        S_DAY_REM,
        S_TICK,
        S_CAP_WAIT,
        S_QDAY,
        S_QNEXT,
        S_SEC,
        S_SEC_MUL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_HOUR;
                end
            end
            S_HOUR: begin
                o_cmd.hr_mul = 1'b1;
                n_state      = S_HOUR_FIX;
            end
            S_HOUR_FIX: begin
                o_cmd.hr_rem = 1'b1;
                n_state      = S_HOUR_ADJ;
            end
            S_HOUR_ADJ: begin
                o_cmd.save_hour = 1'b1;
                n_state         = S_DAY;
            end
            S_DAY: begin
                o_cmd.day_mul = 1'b1;
                n_state       = S_DAY_REM;
            end
            S_DAY_REM: begin
                o_cmd.save_day = 1'b1;
                n_state        = i_stat.is_query ? S_QDAY : S_TICK;
            end
            S_TICK: begin
                o_cmd.tick_eval = 1'b1;
                if (i_stat.cap_hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_CAP_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CAP_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.save_cap = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_QDAY: begin
                o_cmd.calc_day = 1'b1;
                n_state        = S_QNEXT;
            end
            S_QNEXT: begin
                o_cmd.calc_next = 1'b1;
                n_state         = S_SEC;
            end
            S_SEC: begin
                o_cmd.sec_add = 1'b1;
                n_state       = S_SEC_MUL;
            end
            S_SEC_MUL: begin
                o_cmd.save_secs = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `PDES_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `PDES_ASSERT(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load |-> (!r_out_valid || i_out_ready))
    `PDES_ASSERT(a_div_only_busy, i_clk, i_rst_n, o_cmd.div_start |-> !o_in_ready)
    `PDES_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_out_valid && o_in_ready))

endmodule

/* hdl/periodic_and_daily_event_scheduler.sv */
// ---------------------------------------------------------------------------
// periodic_and_daily_event_scheduler
// Tick-driven capture and daily event flags with sleep-time queries.
// ---------------------------------------------------------------------------
// One word goes in, one word comes out. A tick (tuser = 0) reports whether a
// periodic capture is due and whether the once-a-day event fires, and moves
// the schedule forward; a query (tuser = 1) reports whole seconds, rounded
// up, until the nearer event, limited by the optional cap. Every word first
// splits the time into hour and day with reciprocal multiplies. A tick that
// captures then runs the bit-serial divider for the catch-up remainder; a
// query instead works out the sleep time. The next word is taken at the
// earliest in the cycle after the result is loaded, so no new word is taken
// until the last one is through; a result left waiting holds the next word
// in its final step until the output register frees.
// Settings may be written at any time the block is idle; there is no
// clearing pass after reset.
// ---------------------------------------------------------------------------
module periodic_and_daily_event_scheduler
    import pdes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [NOW_W-1:0]  s_axis_tdata,  // [47:0] now_ms
    input  logic              s_axis_tuser,  // [0] func
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,  // [17:0] sleep_seconds, [23:18] zero
    output logic [1:0]        m_axis_tuser   // [0] capture_due, [1] daily_due
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [SECS_W-1:0] w_secs;

    // settings are taken in any cycle
    assign o_cfg_ready = 1'b1;

    pdes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pdes_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (s_axis_tuser),
        .i_now_ms        (s_axis_tdata),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_capture_due   (m_axis_tuser[0]),
        .o_daily_due     (m_axis_tuser[1]),
        .o_sleep_seconds (w_secs)
    );

    // pad the seconds out to whole bytes
    assign m_axis_tdata = {6'd0, w_secs};

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the periodic and daily event scheduler
// Drives ticks and sleep queries with random gaps and stalls, predicts each
// result word from a local copy of the schedule state, and compares them.
// ---------------------------------------------------------------------------
import pdes_pkg::*;

class sched_scoreboard;
    logic [31:0] interval_s;
    logic [4:0]  hour_cfg;
    logic [31:0] cap_s;
    logic [48:0] next_cap;
    logic [22:0] fired_day;
    bit          fired_ok;
    logic [1:0]  flags_q[$];
    logic [17:0] secs_q[$];
    int          errors;

    function new();
        interval_s = 0; hour_cfg = 0; cap_s = 0;
        next_cap = 0; fired_day = 0; fired_ok = 0; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        if (idx == CFG_INTERVAL) interval_s = val;
        else if (idx == CFG_HOUR) hour_cfg = val[4:0];
        else if (idx == CFG_CAP) cap_s = val;
    endfunction

    function longint unsigned period_ms();
        longint unsigned iv;
        iv = longint'(interval_s) * 1000;
        return (iv == 0) ? 3600000 : iv;
    endfunction

    // compute the result of one accepted word and queue it
    function void note_word(logic func, logic [47:0] now_ms);
        longint unsigned now, iv, base, steps, day, hr, fire, to_cap, to_day;
        longint unsigned nxt, lim, secs;
        logic cap, dly;
        now = now_ms; iv = period_ms(); cap = 0; dly = 0;
        day = now / 86400000;
        if (func == FUNC_TICK) begin
            if (next_cap == 0 || now >= next_cap) begin
                base = (next_cap == 0) ? now : longint'(next_cap);
                steps = (now - base) / iv + 1;
                cap = 1;
                next_cap = base + steps * iv;
            end
            hr = (now / 3600000) % 24;
            if (hr == hour_cfg && !(fired_ok && fired_day == day)) begin
                dly = 1;
                fired_day = day;
                fired_ok = 1;
            end
            flags_q.push_back({dly, cap});
            secs_q.push_back(0);
        end else begin
            to_cap = (next_cap > now) ? longint'(next_cap) - now : iv;
            fire = day * 86400000 + longint'(hour_cfg) * 3600000;
            if (now < fire && !(fired_ok && fired_day == day)) to_day = fire - now;
            else to_day = fire + 86400000 - now;
            nxt = (to_cap < to_day) ? to_cap : to_day;
            lim = longint'(cap_s) * 1000;
            if (lim > 0 && lim < nxt) nxt = lim;
            secs = (nxt + 999) / 1000;
            if (secs == 0) secs = 1;
            flags_q.push_back(2'b00);
            secs_q.push_back(secs[17:0]);
        end
    endfunction

    function void check_word(logic [1:0] flags, logic [23:0] data);
        logic [1:0]  exp_flags;
        logic [17:0] exp_secs;
        if (flags_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word flags=%b data=%0d", flags, data);
            return;
        end
        exp_flags = flags_q.pop_front();
        exp_secs = secs_q.pop_front();
        if (flags !== exp_flags || data !== {6'd0, exp_secs}) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: flags exp %b got %b, secs exp %0d got %0d",
                         exp_flags, flags, exp_secs, data);
        end
    endfunction

    function int pending();
        return flags_q.size();
    endfunction
endclass

module tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    sched_scoreboard sb;
    bit              calm;      // suppress random idling on both sides
    bit              hold_out;  // long receiver hold-off in progress
    int              hold_len;
    logic [47:0]     base_ms;

    periodic_and_daily_event_scheduler uut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, plus the long hold-off on request
    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_out && hold_len > 0) begin
                m_axis_tready <= 0;
                hold_len--;
                if (hold_len == 0) hold_out = 0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 18);
            end
        end
    end

    // sample results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tuser, m_axis_tdata);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // drain all results, then let the block settle before reconfiguring
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic send_word(logic func, logic [47:0] now_ms);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 18) @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tuser <= func;
        s_axis_tdata <= now_ms;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(func, now_ms);
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    // mostly forward-moving time with random steps, some jumps and rewinds
    task automatic random_run(int count);
        logic [47:0] t;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0: t = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
                1: t = base_ms - $urandom_range(7200000);
                2: t = base_ms + 86400000 * $urandom_range(3);
                default: t = base_ms + $urandom_range(($urandom_range(1)) ? 4000000 : 20000);
            endcase
            if ($urandom_range(3) != 0) base_ms = t;
            send_word($urandom_range(1), t);
        end
    endtask

    initial begin
        sb = new();
        calm = 0; hold_out = 0; hold_len = 0;
        i_rst_n = 0;
        i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: reset settings, first tick, field extremes
        send_word(FUNC_QUERY, 48'd0);
        send_word(FUNC_TICK, 48'd0);
        send_word(FUNC_QUERY, 48'd0);
        send_word(FUNC_TICK, 48'd3599999);
        send_word(FUNC_TICK, 48'd3600000);
        send_word(FUNC_TICK, 48'd1000);
        send_word(FUNC_QUERY, 48'd1000);
        send_word(FUNC_TICK, 48'hFFFF_FFFF_FFFF);
        send_word(FUNC_QUERY, 48'hFFFF_FFFF_FFFF);
        send_word(FUNC_QUERY, 48'h5555_5555_5555);
        send_word(FUNC_TICK, 48'hAAAA_AAAA_AAAA);
        wait_idle();

        // out-of-range hour, small interval, small cap
        write_reg(CFG_INTERVAL, 32'd1);
        write_reg(CFG_HOUR, 5'd31);
        write_reg(CFG_CAP, 32'd1);
        send_word(FUNC_TICK, 48'd86400000 * 5 + 48'd1);
        send_word(FUNC_QUERY, 48'd86400000 * 5 + 48'd1);
        send_word(FUNC_QUERY, 48'd86400000 * 5 + 48'd1001);
        wait_idle();
        write_reg(CFG_CAP, 32'd0);
        send_word(FUNC_QUERY, 48'd86400000 * 5 + 48'd3);
        send_word(FUNC_TICK, 48'd86400000 * 5 + 48'd1001);
        wait_idle();

        // largest interval and cap, latest valid hour
        write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
        write_reg(CFG_HOUR, 5'd23);
        write_reg(CFG_CAP, 32'hFFFF_FFFF);
        send_word(FUNC_TICK, 48'd86400000 * 9 + 48'd3600000 * 23);
        send_word(FUNC_TICK, 48'd86400000 * 9 + 48'd3600000 * 23 + 48'd5);
        send_word(FUNC_QUERY, 48'd86400000 * 9 + 48'd3600000 * 23 + 48'd5);
        send_word(FUNC_QUERY, 48'd86400000 * 9 + 48'd10);
        send_word(FUNC_TICK, 48'd10);
        wait_idle();

        // random phases across several settings
        base_ms = 48'd86400000 * 20000;
        for (int ph = 0; ph < 14; ph++) begin
            write_reg(CFG_INTERVAL, ($urandom_range(4) == 0) ? $urandom :
                      $urandom_range(7200));
            write_reg(CFG_HOUR, ($urandom_range(5) == 0) ? $urandom_range(31) :
                      $urandom_range(23));
            write_reg(CFG_CAP, ($urandom_range(2) == 0) ? 32'd0 :
                      (($urandom_range(3) == 0) ? $urandom : $urandom_range(5000)));
            if (ph == 3) begin
                hold_len = 3000;
                hold_out = 1;
            end
            calm = (ph == 6);
            random_run(100);
            wait_idle();
        end
        calm = 0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* periodic_and_daily_event_scheduler.f */
+incdir+hdl
hdl/pdes_pkg.sv
hdl/pdes_div.sv
hdl/pdes_dp.sv
hdl/pdes_ctrl.sv
hdl/periodic_and_daily_event_scheduler.sv
tb/tb.sv
